[rtl/slr_pkg.sv]
`default_nettype none
package slr_pkg;

  localparam int PANEL_WIDTH = 56;
  localparam int PANEL_ROWS  = 8;

  localparam int X_W     = 6;
  localparam int Y_W     = 4;
  localparam int COORD_W = 6;
  localparam int COLOR_W = 24;
  localparam int IDX_W   = 9;
  // Wide enough for (row - 1) * PANEL_WIDTH + PANEL_WIDTH before masking.
  localparam int IDX_FULL_W = 12;
  // Signed error term: spans -run .. run/2.
  localparam int ERR_W   = COORD_W + 2;

  typedef struct packed {
    logic [X_W-1:0]     start_x;
    logic [Y_W-1:0]     start_y;
    logic [X_W-1:0]     end_x;
    logic [Y_W-1:0]     end_y;
    logic [COLOR_W-1:0] line_color;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   led_index;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } out_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DRAW
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } ctrl_t;

endpackage
`default_nettype wire

[rtl/slr_seq.sv]
`default_nettype none
module slr_seq (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  input  wire             out_free,
  input  wire             last,
  output logic            in_ready,
  output slr_pkg::ctrl_t  ctrl,
  output slr_pkg::state_t state
);

  slr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = slr_pkg::ST_DRAW;
        end
      end
      slr_pkg::ST_DRAW: begin
        if (out_free && last) begin
          state_nxt = slr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = slr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ctrl.load = 1'b0;
    ctrl.step = 1'b0;
    unique case (state_r)
      slr_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      slr_pkg::ST_DRAW: begin
        ctrl.step = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign state = state_r;

endmodule
`default_nettype wire

[rtl/slr_dp.sv]
`default_nettype none
module slr_dp (
  input  wire            clk,
  input  wire            rst_n,
  input  slr_pkg::ctrl_t ctrl,
  input  slr_pkg::in_t   in_data,
  output slr_pkg::out_t  pixel,
  output logic           last
);

  localparam int CW = slr_pkg::COORD_W;
  localparam int EW = slr_pkg::ERR_W;
  localparam int FW = slr_pkg::IDX_FULL_W;

  // Clamp a coordinate into 1..hi.
  function automatic logic [CW-1:0] sat_coord(input logic [CW-1:0] v,
                                              input logic [CW-1:0] hi);
    logic [CW-1:0] r;
    begin
      r = v;
      if (v == '0) begin
        r = CW'(1);
      end else if (v > hi) begin
        r = hi;
      end
      return r;
    end
  endfunction

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b);
    begin
      return (a > b) ? (a - b) : (b - a);
    end
  endfunction

  logic [CW-1:0] ax, ay, bx, by;
  logic [CW-1:0] p0_maj, p0_mnr, p1_maj, p1_mnr;
  logic [CW-1:0] s_maj, s_mnr, s_end, s_run;
  logic          steep;

  logic [CW-1:0]               maj_r, end_r, mnr_r, run_r, rise_r;
  logic signed [EW-1:0]        err_r;
  logic                        dir_up_r, steep_r, busy_r;
  logic [slr_pkg::COLOR_W-1:0] color_r;

  logic signed [EW-1:0] err_dec;
  logic [CW-1:0]        row, col;
  logic [FW-1:0]        row_m1, base, idx_odd, idx_even, idx;

  // Set-up: clamp, choose the major axis and order the endpoints.
  always_comb begin
    ax = sat_coord(in_data.start_x, CW'(slr_pkg::PANEL_WIDTH));
    bx = sat_coord(in_data.end_x, CW'(slr_pkg::PANEL_WIDTH));
    ay = sat_coord(CW'(in_data.start_y), CW'(slr_pkg::PANEL_ROWS));
    by = sat_coord(CW'(in_data.end_y), CW'(slr_pkg::PANEL_ROWS));
    steep  = abs_diff(ay, by) > abs_diff(ax, bx);
    p0_maj = steep ? ay : ax;
    p0_mnr = steep ? ax : ay;
    p1_maj = steep ? by : bx;
    p1_mnr = steep ? bx : by;
    if (p1_maj < p0_maj) begin
      s_maj = p1_maj;
      s_mnr = p1_mnr;
      s_end = p0_maj;
    end else begin
      s_maj = p0_maj;
      s_mnr = p0_mnr;
      s_end = p1_maj;
    end
    s_run = s_end - s_maj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (ctrl.load) begin
      busy_r   <= 1'b1;
      maj_r    <= s_maj;
      end_r    <= s_end;
      mnr_r    <= s_mnr;
      run_r    <= s_run;
      rise_r   <= abs_diff(p0_mnr, p1_mnr);
      err_r    <= EW'(s_run >> 1);
      dir_up_r <= (p0_maj <= p1_maj) ? (p0_mnr < p1_mnr) : (p1_mnr < p0_mnr);
      steep_r  <= steep;
      color_r  <= in_data.line_color;
    end else if (ctrl.step) begin
      maj_r <= maj_r + CW'(1);
      if (err_dec < 0) begin
        mnr_r <= dir_up_r ? (mnr_r + CW'(1)) : (mnr_r - CW'(1));
        err_r <= err_dec + $signed(EW'(run_r));
      end else begin
        err_r <= err_dec;
      end
      if (maj_r == end_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign err_dec = err_r - $signed(EW'(rise_r));

  // Serpentine mapping: odd rows count down from the row's top index.
  always_comb begin
    row      = steep_r ? maj_r : mnr_r;
    col      = steep_r ? mnr_r : maj_r;
    row_m1   = FW'(row) - FW'(1);
    base     = row_m1 * FW'(slr_pkg::PANEL_WIDTH);
    idx_odd  = base + FW'(slr_pkg::PANEL_WIDTH) - FW'(col);
    idx_even = base + FW'(col) - FW'(1);
    idx      = row[0] ? idx_odd : idx_even;
  end

  assign last              = busy_r && (maj_r == end_r);
  assign pixel.led_index   = idx[slr_pkg::IDX_W-1:0];
  assign pixel.pixel_color = color_r;
  assign pixel.last_pixel  = (maj_r == end_r);

endmodule
`default_nettype wire

[rtl/serpentine_line_rasterizer.sv]
`default_nettype none
// Serpentine line rasterizer: one line command in, one pixel transaction per drawn pixel out.
// The command is registered in the datapath, and each pixel is then registered in the output register.
// Throughput: one pixel per cycle while the output is ready; a line holds at most
// PANEL_WIDTH = 56 pixels, and no new command is taken until its last pixel is emitted.
// Reset: synchronous, active-low rst_n returns the sequencer to idle and empties the output.
module serpentine_line_rasterizer (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_valid,
  output logic          in_ready,
  input  slr_pkg::in_t  in_data,
  output logic          out_valid,
  input  wire           out_ready,
  output slr_pkg::out_t out_data
);

  // The sequencer holds off new commands while a line is being walked. Every cycle in the
  // draw state in which the output register is free (empty, or being taken this cycle), the
  // step unit emits the current pixel and advances the Bresenham error term.
  slr_pkg::ctrl_t  ctrl;
  slr_pkg::state_t state;
  slr_pkg::out_t   pixel;
  logic            last;
  logic            out_free;

  logic          out_valid_r;
  slr_pkg::out_t out_data_r;

  assign out_free = !out_valid_r || out_ready;

  slr_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .last     (last),
    .in_ready (in_ready),
    .ctrl     (ctrl),
    .state    (state)
  );

  slr_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .in_data (in_data),
    .pixel   (pixel),
    .last    (last)
  );

  // Output register: decouples the pixel walk from the consumer's ready. A new command may
  // be accepted while the final pixel of the previous line still waits here, since set-up
  // only touches the datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      out_data_r <= pixel;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A loaded command always moves the sequencer into the draw state.
  a_load_draws: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load |=> state == slr_pkg::ST_DRAW)
    else $error("command loaded but sequencer not drawing");

  // Pixels are only emitted while a line is being walked.
  a_step_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.step |-> state == slr_pkg::ST_DRAW)
    else $error("pixel emitted outside the draw state");

  // Emitting the final pixel of a line frees the block for the next command.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.step && last) |=> in_ready)
    else $error("block not ready after the final pixel");

  // The final pixel flag and the sequencer's end of line agree.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.step |=> (out_data.last_pixel == $past(last)))
    else $error("last pixel flag disagrees with the sequencer");

endmodule
`default_nettype wire
